// ===== src/palette_quantize_pack_defines.svh =====
// Assertion macros for the palette quantizer and packer.
// Included by the top level; depends on nothing else.
`ifndef PALETTE_QUANTIZE_PACK_DEFINES_SVH
`define PALETTE_QUANTIZE_PACK_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PQP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("palette_quantize_pack: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PQP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("palette_quantize_pack: next-cycle check failed");

`endif

// ===== src/pqp_pkg.sv =====
// Shared types, constants and functions of the palette quantizer and packer.
// Used by the channel interfaces and the top level; depends on nothing.
package pqp_pkg;

    localparam int NUM_ENTRIES = 6;
    localparam int CHAN_W      = 8;
    localparam int COLOR_W     = 3 * CHAN_W;
    localparam int SQ_W        = 2 * CHAN_W;
    localparam int DIST_W      = SQ_W + 2;
    localparam int CODE_W      = 3;
    localparam int NIBBLE_W    = 4;
    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 3;

    typedef logic [CHAN_W-1:0]   chan_t;
    typedef logic [COLOR_W-1:0]  color_t;
    typedef logic [SQ_W-1:0]     sq_t;
    typedef logic [DIST_W-1:0]   dist_t;
    typedef logic [CODE_W-1:0]   code_t;
    typedef logic [BYTE_W-1:0]   byte_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PALETTE_0 = 3'd0,
        CFG_PALETTE_1 = 3'd1,
        CFG_PALETTE_2 = 3'd2,
        CFG_PALETTE_3 = 3'd3,
        CFG_PALETTE_4 = 3'd4,
        CFG_PALETTE_5 = 3'd5
    } cfg_idx_e;

    localparam color_t PALETTE_RESET [NUM_ENTRIES] = '{
        24'h000000, 24'hFFFFFF, 24'hFFF338, 24'hBF0000, 24'h6440FF, 24'h438A1C
    };

    localparam code_t CODE_ENTRY_0 = 3'd0;
    localparam code_t CODE_ENTRY_1 = 3'd1;
    localparam code_t CODE_ENTRY_2 = 3'd2;
    localparam code_t CODE_ENTRY_3 = 3'd3;
    localparam code_t CODE_ENTRY_4 = 3'd5;
    localparam code_t CODE_ENTRY_5 = 3'd6;

    localparam code_t ENTRY_CODE [NUM_ENTRIES] = '{
        CODE_ENTRY_0, CODE_ENTRY_1, CODE_ENTRY_2,
        CODE_ENTRY_3, CODE_ENTRY_4, CODE_ENTRY_5
    };

    function automatic sq_t sq_diff(input chan_t a, input chan_t b);
        chan_t d;
        d = (a >= b) ? chan_t'(a - b) : chan_t'(b - a);
        return sq_t'(d) * sq_t'(d);
    endfunction

    function automatic dist_t color_dist(input chan_t r, input chan_t g, input chan_t b,
                                         input color_t c);
        return dist_t'(sq_diff(r, c[3*CHAN_W-1:2*CHAN_W]))
             + dist_t'(sq_diff(g, c[2*CHAN_W-1:CHAN_W]))
             + dist_t'(sq_diff(b, c[CHAN_W-1:0]));
    endfunction

endpackage

// ===== src/pqp_if.sv =====
// Valid/ready channel interfaces: pixel requests in, packed byte requests out.
// Depends on pqp_pkg for the payload types.
interface pqp_pixel_if;
    import pqp_pkg::*;

    logic  valid;
    logic  ready;
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  row_end;

    modport source (output valid, output red, output green, output blue,
                    output row_end, input ready);
    modport sink (input valid, input red, input green, input blue,
                  input row_end, output ready);
endinterface

interface pqp_byte_if;
    import pqp_pkg::*;

    logic  valid;
    logic  ready;
    byte_t packed_byte;

    modport source (output valid, output packed_byte, input ready);
    modport sink (input valid, input packed_byte, output ready);
endinterface

// ===== src/palette_quantize_pack.sv =====
// Top level: nearest palette color search and two-codes-per-byte packing.
// Depends on pqp_pkg, pqp_if.sv and palette_quantize_pack_defines.svh.
//
//   channel   kind          payload                       per request
//   pixel     valid/ready   red, green, blue, row_end     one pixel
//   pair      valid/ready   packed_byte                   two 3-bit codes
//   cfg       write only    cfg_we, cfg_index, cfg_data   one palette color
//
// A pixel is taken into an input register, and in the next cycle six distance
// units and a six-way minimum pick its code, which waits in the pairing register,
// completes a byte in the output register, or is dropped if its pixel ends a row
// with no code waiting. One pixel per cycle; a stalled output holds only pixels that
// end a pair. Reset clears the pairing state and loads the default palette.
`include "palette_quantize_pack_defines.svh"

module palette_quantize_pack (
    input  logic                             clk,
    input  logic                             rst_n,
    pqp_pixel_if.sink                        pixel,
    pqp_byte_if.source                       pair,
    input  logic                             cfg_we,
    input  logic [pqp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pqp_pkg::COLOR_W-1:0]      cfg_data
);
    import pqp_pkg::*;

    color_t palette_reg [NUM_ENTRIES];

    logic   in_valid_reg;
    chan_t  red_reg;
    chan_t  green_reg;
    chan_t  blue_reg;
    logic   row_end_reg;

    logic   have_first_reg, have_first_next;
    code_t  held_code_reg, held_code_next;
    logic   out_valid_reg, out_valid_next;
    byte_t  packed_byte_reg, packed_byte_next;

    dist_t  entry_dist [NUM_ENTRIES];
    dist_t  best_dist;
    code_t  best_code;
    logic   out_free;
    logic   advance;

    // Palette registers; writes to unused indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < NUM_ENTRIES; e++)
            begin
                palette_reg[e] <= PALETTE_RESET[e];
            end
        end
        else if (cfg_we)
        begin
            case (cfg_idx_e'(cfg_index))
                CFG_PALETTE_0: palette_reg[0] <= cfg_data;
                CFG_PALETTE_1: palette_reg[1] <= cfg_data;
                CFG_PALETTE_2: palette_reg[2] <= cfg_data;
                CFG_PALETTE_3: palette_reg[3] <= cfg_data;
                CFG_PALETTE_4: palette_reg[4] <= cfg_data;
                CFG_PALETTE_5: palette_reg[5] <= cfg_data;
                default: ;
            endcase
        end
    end

    // A held pixel only needs the output register when it completes a pair.
    assign out_free    = !out_valid_reg || pair.ready;
    assign advance     = in_valid_reg && (!have_first_reg || out_free);
    assign pixel.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (pixel.ready)
        begin
            in_valid_reg <= pixel.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel.valid && pixel.ready)
        begin
            red_reg     <= pixel.red;
            green_reg   <= pixel.green;
            blue_reg    <= pixel.blue;
            row_end_reg <= pixel.row_end;
        end
    end

    always_comb
    begin
        for (int e = 0; e < NUM_ENTRIES; e++)
        begin
            entry_dist[e] = color_dist(red_reg, green_reg, blue_reg, palette_reg[e]);
        end
    end

    // Strict less-than keeps the lower entry on a tie.
    always_comb
    begin
        best_dist = entry_dist[0];
        best_code = ENTRY_CODE[0];
        for (int e = 1; e < NUM_ENTRIES; e++)
        begin
            if (entry_dist[e] < best_dist)
            begin
                best_dist = entry_dist[e];
                best_code = ENTRY_CODE[e];
            end
        end
    end

    always_comb
    begin
        have_first_next  = have_first_reg;
        held_code_next   = held_code_reg;
        out_valid_next   = out_valid_reg && !pair.ready;
        packed_byte_next = packed_byte_reg;
        if (advance)
        begin
            if (have_first_reg)
            begin
                have_first_next  = 1'b0;
                held_code_next   = '0;
                out_valid_next   = 1'b1;
                packed_byte_next = {NIBBLE_W'(held_code_reg), NIBBLE_W'(best_code)};
            end
            else if (!row_end_reg)
            begin
                have_first_next = 1'b1;
                held_code_next  = best_code;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_first_reg <= 1'b0;
            held_code_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            have_first_reg <= have_first_next;
            held_code_reg  <= held_code_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        packed_byte_reg <= packed_byte_next;
    end

    assign pair.valid       = out_valid_reg;
    assign pair.packed_byte = packed_byte_reg;

    `PQP_ASSERT_NEXT(a_pair_emits, clk, rst_n, advance && have_first_reg, out_valid_reg && !have_first_reg)
    `PQP_ASSERT_NEXT(a_first_held, clk, rst_n, advance && !have_first_reg && !row_end_reg, have_first_reg)
    `PQP_ASSERT_SAME(a_stall_cause, clk, rst_n, in_valid_reg && !advance, have_first_reg && out_valid_reg && !pair.ready)
    `PQP_ASSERT_NEXT(a_row_end_drop, clk, rst_n, advance && !have_first_reg && row_end_reg, !have_first_reg)

endmodule

// ===== verif/tb_palette_quantize_pack.sv =====
// Testbench for palette_quantize_pack: random and directed pixel requests against a predictor
// of nearest-color search and nibble pairing, with several palettes and handshake stall mixes.
// Depends on pqp_pkg, the channel interfaces in pqp_if.sv and the palette_quantize_pack RTL.
module tb_palette_quantize_pack;
    import pqp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        logic  row_end;
    } pixel_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    color_t cfg_data;

    pqp_pixel_if pixel_ch ();
    pqp_byte_if byte_ch ();

    palette_quantize_pack DUT (clk, rst_n, pixel_ch, byte_ch, cfg_we, cfg_index, cfg_data);

    pixel_t pending_pixels[$];
    byte_t expected_bytes[$];
    color_t palette_model [NUM_ENTRIES];
    code_t held_code;
    logic have_first;
    int sender_idle_pct;
    int receiver_idle_pct;
    int error_count;
    int cycle_count;

    function automatic code_t nearest_code(chan_t r, chan_t g, chan_t b);
        int best_dist;
        int entry_dist;
        int dr;
        int dg;
        int db;
        code_t best;
        best_dist = 0;
        best = ENTRY_CODE[0];
        for (int e = 0; e < NUM_ENTRIES; e++)
        begin
            dr = int'(r) - int'(palette_model[e][23:16]);
            dg = int'(g) - int'(palette_model[e][15:8]);
            db = int'(b) - int'(palette_model[e][7:0]);
            entry_dist = dr * dr + dg * dg + db * db;
            if (e == 0 || entry_dist < best_dist)
            begin
                best_dist = entry_dist;
                best = ENTRY_CODE[e];
            end
        end
        return best;
    endfunction

    function automatic void quantize_and_pair(pixel_t px);
        code_t code;
        code = nearest_code(px.red, px.green, px.blue);
        if (!have_first)
        begin
            if (!px.row_end)
            begin
                held_code = code;
                have_first = 1'b1;
            end
        end
        else
        begin
            expected_bytes.push_back({1'b0, held_code, 1'b0, code});
            held_code = '0;
            have_first = 1'b0;
        end
    endfunction

    task automatic report_mismatch(string what, byte_t got, byte_t want);
        $display("[%0t] mismatch: %s, got 0x%02h, expected 0x%02h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic write_palette(logic [CFG_IDX_W-1:0] index, color_t value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        if (int'(index) < NUM_ENTRIES)
            palette_model[index] = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_palette(color_t pal [NUM_ENTRIES]);
        for (int e = 0; e < NUM_ENTRIES; e++)
            write_palette(CFG_IDX_W'(e), pal[e]);
    endtask

    task automatic push_pixel(chan_t r, chan_t g, chan_t b, logic row_end);
        pending_pixels.push_back('{r, g, b, row_end});
    endtask

    function automatic chan_t jitter(chan_t c);
        int v;
        v = int'(c) + int'($urandom_range(24)) - 12;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return chan_t'(v);
    endfunction

    function automatic pixel_t make_pixel(logic row_end);
        pixel_t px;
        color_t c;
        int pick;
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            c = palette_model[$urandom_range(NUM_ENTRIES - 1)];
            px.red = jitter(c[23:16]);
            px.green = jitter(c[15:8]);
            px.blue = jitter(c[7:0]);
        end
        else if (pick < 50)
        begin
            px.red = $urandom_range(1) ? 8'hFF : 8'h00;
            px.green = $urandom_range(1) ? 8'hFF : 8'h00;
            px.blue = $urandom_range(1) ? 8'hFF : 8'h00;
        end
        else
        begin
            px.red = chan_t'($urandom);
            px.green = chan_t'($urandom);
            px.blue = chan_t'($urandom);
        end
        px.row_end = row_end;
        return px;
    endfunction

    task automatic add_random_rows(int count);
        int pushed;
        int row_len;
        pushed = 0;
        while (pushed < count)
        begin
            if ($urandom_range(9) == 0)
            begin
                pending_pixels.push_back(make_pixel(logic'($urandom_range(1))));
                pushed++;
            end
            else
            begin
                row_len = $urandom_range(1, 9);
                for (int i = 0; i < row_len; i++)
                    pending_pixels.push_back(make_pixel(i == row_len - 1));
                pushed += row_len;
            end
        end
    endtask

    function automatic color_t random_color();
        case ($urandom_range(3))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            default: return color_t'($urandom);
        endcase
    endfunction

    task automatic settle();
        while (pending_pixels.size() != 0 || pixel_ch.valid)
            @(posedge clk);
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin : drive_pixels
        pixel_t px;
        if (!rst_n)
        begin
            pixel_ch.valid <= 1'b0;
        end
        else if (!pixel_ch.valid || pixel_ch.ready)
        begin
            if (pending_pixels.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                px = pending_pixels.pop_front();
                pixel_ch.valid <= 1'b1;
                pixel_ch.red <= px.red;
                pixel_ch.green <= px.green;
                pixel_ch.blue <= px.blue;
                pixel_ch.row_end <= px.row_end;
            end
            else
            begin
                pixel_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_ch.ready <= 1'b0;
        else
            byte_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge clk)
    begin : watch_channels
        byte_t want;
        if (rst_n)
        begin
            if (pixel_ch.valid && pixel_ch.ready)
                quantize_and_pair('{pixel_ch.red, pixel_ch.green, pixel_ch.blue,
                                    pixel_ch.row_end});
            if (byte_ch.valid && byte_ch.ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    report_mismatch("byte request with none expected", byte_ch.packed_byte, '0);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (byte_ch.packed_byte !== want)
                        report_mismatch("packed_byte", byte_ch.packed_byte, want);
                end
            end
        end
    end

    initial
    begin : stimulus
        color_t pal [NUM_ENTRIES];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pixel_ch.valid = 1'b0;
        pixel_ch.red = '0;
        pixel_ch.green = '0;
        pixel_ch.blue = '0;
        pixel_ch.row_end = 1'b0;
        byte_ch.ready = 1'b0;
        error_count = 0;
        cycle_count = 0;
        held_code = '0;
        have_first = 1'b0;
        palette_model = PALETTE_RESET;
        sender_idle_pct = 37;
        receiver_idle_pct = 86;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        push_pixel(8'hFF, 8'hF3, 8'h38, 1'b0);
        push_pixel(8'hBF, 8'h00, 8'h00, 1'b0);
        push_pixel(8'h64, 8'h40, 8'hFF, 1'b0);
        push_pixel(8'h43, 8'h8A, 8'h1C, 1'b1);
        push_pixel(8'hFF, 8'h00, 8'h00, 1'b1);
        push_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
        push_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
        push_pixel(8'h80, 8'h80, 8'h80, 1'b1);
        push_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
        push_pixel(8'h00, 8'hFF, 8'hFF, 1'b1);
        push_pixel(8'h7F, 8'h7F, 8'h7F, 1'b0);
        push_pixel(8'h80, 8'h80, 8'h80, 1'b0);
        push_pixel(8'h01, 8'h02, 8'h04, 1'b1);
        add_random_rows(150);
        settle();

        for (int e = 0; e < NUM_ENTRIES; e++)
            pal[e] = 24'h000000;
        load_palette(pal);
        write_palette(CFG_SPARE_6, 24'hFFFFFF);
        write_palette(CFG_SPARE_7, 24'hFFFFFF);
        add_random_rows(100);
        settle();

        for (int e = 0; e < NUM_ENTRIES; e++)
            pal[e] = 24'hFFFFFF;
        load_palette(pal);
        sender_idle_pct = 86;
        receiver_idle_pct = 37;
        add_random_rows(100);
        settle();

        pal = '{24'h000000, 24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h808080, 24'h808080};
        load_palette(pal);
        push_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        push_pixel(8'h80, 8'h80, 8'h80, 1'b0);
        push_pixel(8'h40, 8'h40, 8'h40, 1'b0);
        push_pixel(8'hC0, 8'hC0, 8'hC0, 1'b0);
        push_pixel(8'h40, 8'h40, 8'h40, 1'b1);
        add_random_rows(150);
        settle();

        for (int e = 0; e < NUM_ENTRIES; e++)
            pal[e] = random_color();
        load_palette(pal);
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        add_random_rows(150);
        settle();

        for (int e = 0; e < NUM_ENTRIES; e++)
            pal[e] = color_t'($urandom);
        load_palette(pal);
        write_palette(CFG_SPARE_6, color_t'($urandom));
        write_palette(CFG_SPARE_7, color_t'($urandom));
        add_random_rows(150);
        settle();

        load_palette(PALETTE_RESET);
        add_random_rows(150);
        settle();

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+src
src/pqp_pkg.sv
src/pqp_if.sv
src/palette_quantize_pack.sv
verif/tb_palette_quantize_pack.sv
